// ===== rtl/lcumac_pkg.sv =====
// Shared constants and types for the modular-prime MAC accumulator.
// No dependencies; every other file in rtl/ but lcumac_checker imports this package.
`default_nettype none

package lcumac_pkg;

    localparam int LIMB_W      = 64;
    localparam int LIMBS       = 4;
    localparam int VAL_W       = 256;
    localparam int WORD_W      = 32;
    localparam int WORDS       = 8;
    localparam int FOLDS       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VAL_W-1:0] PRIME_Q =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;
    localparam logic [9:0] FOLD_C = 10'd977;

    // One complete block as handed from the front end to the arithmetic core.
    typedef struct packed {
        logic [VAL_W-1:0] key_a;
        logic [VAL_W-1:0] key_b;
        logic [VAL_W-1:0] msg;
        logic             msg_end;
    } block_t;

endpackage

`default_nettype wire

// ===== rtl/lcumac_front.sv =====
// Front end: gathers four limbs of a, b and m into one block.
// Depends on lcumac_pkg.
`default_nettype none

module lcumac_front
    import lcumac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [LIMB_W-1:0] key_a_limb,
    input  wire logic [LIMB_W-1:0] key_b_limb,
    input  wire logic [LIMB_W-1:0] message_limb,
    input  wire logic              message_end,
    input  wire logic              full,
    output logic                   push,
    output block_t                 blk
);

    localparam logic [1:0] LAST_LIMB = 2'(LIMBS - 1);

    logic [1:0]        idx_reg;
    logic [LIMB_W-1:0] a_buf_reg [LIMBS-1];
    logic [LIMB_W-1:0] b_buf_reg [LIMBS-1];
    logic [LIMB_W-1:0] m_buf_reg [LIMBS-1];
    logic              beat;

    // Only the closing limb of a block needs room in the queue.
    assign s_tready = (idx_reg != LAST_LIMB) || !full;
    assign beat     = s_tvalid && s_tready;
    assign push     = beat && (idx_reg == LAST_LIMB);

    assign blk.key_a   = {a_buf_reg[0], a_buf_reg[1], a_buf_reg[2], key_a_limb};
    assign blk.key_b   = {b_buf_reg[0], b_buf_reg[1], b_buf_reg[2], key_b_limb};
    assign blk.msg     = {m_buf_reg[0], m_buf_reg[1], m_buf_reg[2], message_limb};
    assign blk.msg_end = message_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (beat)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat && (idx_reg != LAST_LIMB))
        begin
            a_buf_reg[idx_reg] <= key_a_limb;
            b_buf_reg[idx_reg] <= key_b_limb;
            m_buf_reg[idx_reg] <= message_limb;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcumac_fifo.sv =====
// Short block queue between the front end and the arithmetic core.
// Depends on lcumac_pkg.
`default_nettype none

module lcumac_fifo
    import lcumac_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  block_t      wr_data,
    output logic        full,
    input  wire logic   pop,
    output block_t      rd_data,
    output logic        empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LAST_PTR = PtrW'(Depth - 1);

    block_t          mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CntW'(Depth));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcumac_core.sv =====
// Arithmetic core: a*m mod q on a single 32x32 multiplier, word-serial folding,
// the two modular additions, the running tag and the tag output register.
// Depends on lcumac_pkg.
`default_nettype none

module lcumac_core
    import lcumac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  block_t                 blk,
    input  wire logic              blk_valid,
    output logic                   pop,
    output logic                   tag_valid,
    input  wire logic              tag_ready,
    output logic [LIMB_W-1:0]      tag_limb,
    output logic                   tag_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_FOLD, S_SUB, S_ADDB, S_ADDS, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        P_MUL, P_ADDB, P_ADDS
    } phase_t;

    localparam logic [3:0] LAST_COL  = 4'(2 * WORDS - 2);
    localparam logic [3:0] LAST_WORD = 4'(WORDS + 1);
    localparam logic [1:0] LAST_FOLD = 2'(FOLDS - 1);

    state_t              state_reg;
    phase_t              phase_reg;
    logic [2*VAL_W-1:0]  x_reg;
    logic [VAL_W-1:0]    sigma_reg;
    logic [3:0]          col_reg;
    logic [2:0]          row_reg;
    logic                issue_done_reg;
    logic                prod_valid_reg;
    logic                prod_last_reg;
    logic [63:0]         prod_reg;
    logic [69:0]         acc_reg;
    logic [3:0]          word_reg;
    logic [1:0]          fold_reg;
    logic                sub_reg;
    logic [WORD_W-1:0]   hprev_reg;
    logic [10:0]         carry_reg;
    logic [VAL_W-1:0]    tag_reg;
    logic [2:0]          tag_left_reg;
    logic                out_valid_reg;
    logic [LIMB_W-1:0]   out_data_reg;
    logic                out_last_reg;

    logic [2:0]          row_hi;
    logic [3:0]          col_inc;
    logic [2:0]          row_lo_inc;
    logic [2:0]          j_idx;
    logic [WORD_W-1:0]   a_word;
    logic [WORD_W-1:0]   m_word;
    logic [69:0]         acc_sum;
    logic [WORD_W-1:0]   lw;
    logic [WORD_W-1:0]   hw;
    logic [41:0]         fold_prod;
    logic [42:0]         fold_sum;
    logic [VAL_W:0]      sub_diff;
    logic [VAL_W:0]      add_b_sum;
    logic [VAL_W:0]      add_s_sum;

    // Column-ordered schoolbook product: column k pairs word i of a with word k-i of m.
    assign row_hi     = (col_reg > 4'd7) ? 3'd7 : col_reg[2:0];
    assign col_inc    = col_reg + 4'd1;
    assign row_lo_inc = (col_inc > 4'd7) ? 3'(col_inc - 4'd7) : 3'd0;
    assign j_idx      = 3'(col_reg - {1'b0, row_reg});
    assign a_word     = blk.key_a[WORD_W*row_reg +: WORD_W];
    assign m_word     = blk.msg[WORD_W*j_idx +: WORD_W];
    assign acc_sum    = acc_reg + {6'b0, prod_reg};

    // Fold: low half plus high half times 2^32 + 977, one word per cycle.
    assign lw        = word_reg[3] ? '0 : x_reg[WORD_W-1:0];
    assign hw        = word_reg[3] ? '0 : x_reg[VAL_W +: WORD_W];
    assign fold_prod = {10'b0, hw} * {32'b0, FOLD_C};
    assign fold_sum  = 43'(lw) + 43'(fold_prod) + 43'(hprev_reg) + 43'(carry_reg);

    assign sub_diff  = {1'b0, x_reg[VAL_W-1:0]} - {1'b0, PRIME_Q};
    assign add_b_sum = {1'b0, x_reg[VAL_W-1:0]} + {1'b0, blk.key_b};
    assign add_s_sum = {1'b0, sigma_reg} + {1'b0, x_reg[VAL_W-1:0]};

    assign pop       = (state_reg == S_FIN) && (!blk.msg_end || (tag_left_reg == 3'd0));
    assign tag_valid = out_valid_reg;
    assign tag_limb  = out_data_reg;
    assign tag_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= P_MUL;
            x_reg          <= '0;
            sigma_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            issue_done_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            word_reg       <= '0;
            fold_reg       <= '0;
            sub_reg        <= 1'b0;
            hprev_reg      <= '0;
            carry_reg      <= '0;
            tag_reg        <= '0;
            tag_left_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Tag output register, fed from the tag shift register.
            if ((!out_valid_reg || tag_ready) && (tag_left_reg != 3'd0))
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= tag_reg[VAL_W-1 -: LIMB_W];
                out_last_reg  <= (tag_left_reg == 3'd1);
                tag_reg       <= tag_reg << LIMB_W;
                tag_left_reg  <= tag_left_reg - 3'd1;
            end
            else if (out_valid_reg && tag_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (blk_valid)
                    begin
                        col_reg        <= '0;
                        row_reg        <= '0;
                        issue_done_reg <= 1'b0;
                        acc_reg        <= '0;
                        phase_reg      <= P_MUL;
                        state_reg      <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    prod_valid_reg <= !issue_done_reg;
                    if (!issue_done_reg)
                    begin
                        prod_reg       <= {32'b0, a_word} * {32'b0, m_word};
                        prod_last_reg  <= (row_reg == row_hi);
                        if (row_reg == row_hi)
                        begin
                            if (col_reg == LAST_COL)
                            begin
                                issue_done_reg <= 1'b1;
                            end
                            else
                            begin
                                col_reg <= col_inc;
                                row_reg <= row_lo_inc;
                            end
                        end
                        else
                        begin
                            row_reg <= row_reg + 3'd1;
                        end
                    end

                    if (prod_valid_reg)
                    begin
                        if (prod_last_reg)
                        begin
                            x_reg   <= {acc_sum[WORD_W-1:0], x_reg[2*VAL_W-1:WORD_W]};
                            acc_reg <= {32'b0, acc_sum[69:32]};
                        end
                        else
                        begin
                            acc_reg <= acc_sum;
                        end
                    end
                    else if (issue_done_reg)
                    begin
                        // The carry left over is the top word of the product.
                        x_reg     <= {acc_reg[WORD_W-1:0], x_reg[2*VAL_W-1:WORD_W]};
                        word_reg  <= '0;
                        fold_reg  <= '0;
                        hprev_reg <= '0;
                        carry_reg <= '0;
                        state_reg <= S_FOLD;
                    end
                end

                S_FOLD:
                begin
                    if (!word_reg[3])
                    begin
                        x_reg[VAL_W-1:0] <= {fold_sum[WORD_W-1:0], x_reg[VAL_W-1:WORD_W]};
                        x_reg[2*VAL_W-1:VAL_W] <=
                            {32'b0, x_reg[2*VAL_W-1:VAL_W+WORD_W]};
                    end
                    else if (word_reg == 4'd8)
                    begin
                        x_reg[VAL_W +: WORD_W] <= fold_sum[WORD_W-1:0];
                    end
                    else
                    begin
                        x_reg[VAL_W+WORD_W +: WORD_W] <= fold_sum[WORD_W-1:0];
                    end

                    if (word_reg == LAST_WORD)
                    begin
                        word_reg  <= '0;
                        hprev_reg <= '0;
                        carry_reg <= '0;
                        if (fold_reg == LAST_FOLD)
                        begin
                            sub_reg   <= 1'b0;
                            state_reg <= S_SUB;
                        end
                        else
                        begin
                            fold_reg <= fold_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        hprev_reg <= hw;
                        carry_reg <= fold_sum[42:32];
                        word_reg  <= word_reg + 4'd1;
                    end
                end

                S_SUB:
                begin
                    if (!sub_diff[VAL_W])
                    begin
                        x_reg[VAL_W-1:0] <= sub_diff[VAL_W-1:0];
                    end
                    if (sub_reg)
                    begin
                        unique case (phase_reg)
                            P_MUL:   state_reg <= S_ADDB;
                            P_ADDB:  state_reg <= S_ADDS;
                            P_ADDS:  state_reg <= S_FIN;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                    else
                    begin
                        sub_reg <= 1'b1;
                    end
                end

                S_ADDB:
                begin
                    x_reg     <= {255'b0, add_b_sum};
                    phase_reg <= P_ADDB;
                    word_reg  <= '0;
                    fold_reg  <= '0;
                    hprev_reg <= '0;
                    carry_reg <= '0;
                    state_reg <= S_FOLD;
                end

                S_ADDS:
                begin
                    x_reg     <= {255'b0, add_s_sum};
                    phase_reg <= P_ADDS;
                    word_reg  <= '0;
                    fold_reg  <= '0;
                    hprev_reg <= '0;
                    carry_reg <= '0;
                    state_reg <= S_FOLD;
                end

                S_FIN:
                begin
                    if (!blk.msg_end)
                    begin
                        sigma_reg <= x_reg[VAL_W-1:0];
                        state_reg <= S_IDLE;
                    end
                    else if (tag_left_reg == 3'd0)
                    begin
                        // Hand the finished tag to the output side and start afresh.
                        tag_reg      <= x_reg[VAL_W-1:0];
                        tag_left_reg <= 3'(LIMBS);
                        sigma_reg    <= '0;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lc_umac_mod_prime_accumulate.sv =====
// Block MAC accumulator over q = 2^256 - 2^32 - 977. Each input beat carries one
// 64-bit limb of key a, key b and message m, most significant first; every fourth
// beat closes a block and the tag becomes sigma + ((a*m mod q) + b) mod q, reduced
// mod q. With tlast on a closing beat the tag leaves as four 64-bit beats, most
// significant first (tlast on the last), and the tag restarts at zero. Limbs one
// to three of a block are always taken at once; the arithmetic throughput is set
// by the single 32x32 multiplier that forms the 64 partial products and by the
// word-serial fold unit (three folds for each of the three reductions). Up to
// QueueDepth blocks wait between the front end and the core.
// Depends on lcumac_pkg, lcumac_front, lcumac_fifo and lcumac_core.
`default_nettype none

module lc_umac_mod_prime_accumulate
    import lcumac_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [191:0]  s_tdata,   // key_a_limb, key_b_limb, message_limb
    input  wire logic          s_tlast,   // message_end
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // tag_limb
    output logic               m_tlast    // tag_last
);

    block_t fr_blk;
    block_t q_blk;
    logic   fr_push;
    logic   q_full;
    logic   q_empty;
    logic   core_pop;

    lcumac_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .key_a_limb   (s_tdata[63:0]),
        .key_b_limb   (s_tdata[127:64]),
        .message_limb (s_tdata[191:128]),
        .message_end  (s_tlast),
        .full         (q_full),
        .push         (fr_push),
        .blk          (fr_blk)
    );

    lcumac_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fr_push),
        .wr_data (fr_blk),
        .full    (q_full),
        .pop     (core_pop),
        .rd_data (q_blk),
        .empty   (q_empty)
    );

    lcumac_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (q_blk),
        .blk_valid (!q_empty),
        .pop       (core_pop),
        .tag_valid (m_tvalid),
        .tag_ready (m_tready),
        .tag_limb  (m_tdata),
        .tag_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/lcumac_checker.sv =====
// Port-level checks for the MAC accumulator, bound to the top level.
// No package dependencies.
`default_nettype none

module lcumac_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         s_tlast,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic         m_tlast
);

    logic [1:0] in_cnt_reg;
    logic [1:0] out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= 2'd0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_cnt_reg <= in_cnt_reg + 2'd1;
            end
            if (m_tvalid && m_tready)
            begin
                out_cnt_reg <= out_cnt_reg + 2'd1;
            end
        end
    end

    // A stalled tag beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("tag beat changed while stalled");

    // Tags come out whole: tlast marks every fourth beat and only that one.
    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> (m_tlast == (out_cnt_reg == 2'd3)))
        else $error("tlast out of step with tag limbs");

    // Only the closing limb of a block may be held back.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && (in_cnt_reg != 2'd3) |-> s_tready)
        else $error("inner limb of a block was stalled");

    // Nothing is offered straight out of reset.
    a_rst_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("tag beat valid straight after reset");

    logic unused_tlast;
    assign unused_tlast = s_tlast;

endmodule

bind lc_umac_mod_prime_accumulate lcumac_checker u_lcumac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/lc_umac_mod_prime_accumulate_test.sv =====
// Self-checking testbench for the modular-prime MAC accumulator.
// Drives limb beats with random gaps and stalls and checks every tag beat
// against an internal 256-bit predictor. Depends on lcumac_pkg and the RTL.
`timescale 1ns / 100ps

module lc_umac_mod_prime_accumulate_test;
    import lcumac_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tlast;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] m;
        logic        fin;
    } limb_beat_t;

    typedef struct {
        logic [63:0] tag;
        logic        last;
    } tag_beat_t;

    localparam logic [63:0] ONES = 64'hFFFFFFFFFFFFFFFF;

    limb_beat_t  beats[$];
    tag_beat_t   tags_due[$];
    int          errors = 0;
    int          tags_seen = 0;
    int          sent = 0;
    int          hold_off = 0;
    bit          sending_done = 0;
    logic [VAL_W-1:0] sigma = '0;
    logic [63:0] a_limbs[4], b_limbs[4], m_limbs[4];
    int          limb_idx = 0;

    lc_umac_mod_prime_accumulate dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Folds the tag update for one completed block into sigma, wide arithmetic.
    task automatic accumulate_block(input logic fin);
        logic [VAL_W-1:0] ka, kb, km;
        logic [511:0] prod;
        int k;
        ka = {a_limbs[0], a_limbs[1], a_limbs[2], a_limbs[3]};
        kb = {b_limbs[0], b_limbs[1], b_limbs[2], b_limbs[3]};
        km = {m_limbs[0], m_limbs[1], m_limbs[2], m_limbs[3]};
        prod = ka * km;
        prod = prod % PRIME_Q;
        prod = (prod + kb) % PRIME_Q;
        prod = (prod + sigma) % PRIME_Q;
        sigma = prod[VAL_W-1:0];
        if (fin)
        begin
            for (k = 0; k < 4; k++)
                tags_due.push_back('{sigma[255-64*k -: 64], k == 3});
            sigma = '0;
        end
    endtask

    task automatic predict_beat(input limb_beat_t bt);
        a_limbs[limb_idx] = bt.a;
        b_limbs[limb_idx] = bt.b;
        m_limbs[limb_idx] = bt.m;
        if (limb_idx == 3)
            accumulate_block(bt.fin);
        limb_idx = (limb_idx + 1) % 4;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic add_block(input logic [63:0] a[4], input logic [63:0] b[4],
                             input logic [63:0] m[4], input logic fin, input bit stray);
        int k;
        for (k = 0; k < 4; k++)
            beats.push_back('{a[k], b[k], m[k], (k == 3) ? fin : (stray & $urandom_range(0, 1))});
    endtask

    // Directed table: extremes of keys and message, end flag on inner limbs,
    // values above q, and the trivial all-zero block whose tag is known.
    initial
    begin
        logic [63:0] z[4], o[4], r1[4], r2[4], r3[4], qv[4];
        int n, k, gap;
        z = '{default: 64'h0};
        o = '{default: ONES};
        qv = '{ONES, ONES, ONES, 64'hFFFFFFFEFFFFFC2F};
        add_block(z, z, z, 1'b1, 0);          // tag of all zeros is zero
        add_block(o, o, o, 1'b1, 1);          // all ones, stray end flags
        add_block(qv, qv, o, 1'b0, 0);        // keys equal to q
        add_block(o, z, qv, 1'b1, 1);
        for (k = 0; k < 4; k++)
        begin
            r1[k] = rand64(); r2[k] = rand64(); r3[k] = rand64();
        end
        add_block(r1, r2, r3, 1'b1, 1);
        add_block(z, o, z, 1'b1, 0);          // b alone above q: b mod q
        // Random messages of one to four blocks, with stray inner end flags.
        while (beats.size() < 100)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                for (k = 0; k < 4; k++)
                begin
                    r1[k] = rand64(); r2[k] = rand64(); r3[k] = rand64();
                end
                n--;
                add_block(r1, r2, r3, n == 0, $urandom_range(0, 3) == 0);
            end
        end
        tags_due.push_back('{64'h0, 1'b0}); tags_due.pop_back();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (beats.size() > 0)
        begin
            gap = gap_len();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {beats[0].m, beats[0].b, beats[0].a};
            s_tlast  <= beats[0].fin;
            predict_beat(beats[0]);
            void'(beats.pop_front());
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            sent++;
        end
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // Receiver: random stalls plus one long hold-off early on.
    initial
    begin
        int cyc;
        @(posedge rst_n);
        hold_off = 400;
        while (hold_off > 0)
        begin
            @(posedge clk);
            hold_off--;
        end
        forever
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 120)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        tag_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tags_due.size() == 0)
            begin
                report_mismatch("unexpected tag beat", m_tdata, '0);
            end
            else
            begin
                want = tags_due.pop_front();
                tags_seen++;
                if (m_tdata !== want.tag)
                    report_mismatch("tag_limb", m_tdata, want.tag);
                if (m_tlast !== want.last)
                    report_mismatch("tag_last", {63'h0, m_tlast}, {63'h0, want.last});
            end
        end
    end

    initial
    begin
        wait (sending_done);
        wait (tags_due.size() == 0);
        repeat (800) @(posedge clk);
        $display("Sent %0d limb beats, checked %0d tag beats, incl. stalls and stray end flags.",
                 sent, tags_seen);
        if (errors == 0 && tags_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d tag beats outstanding.", tags_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
